>>> sv/rss_pkg.sv
// Reservation station scheduler package: widths, class codes, opcode decode.
// Used by rss_cell, rss_class and reservation_station_scheduler.
package rss_pkg;

  localparam int SLOTS     = 8;   // cells per class row (upper bound of station count)
  localparam int SLOT_W    = 3;
  localparam int CNT_W     = 4;
  localparam int TAG_W     = 5;
  localparam int RETIRED_W = 32;
  localparam int REG_COUNT = 8;
  localparam int REG_W     = 3;
  localparam int NCLASS    = 3;

  localparam logic [CNT_W-1:0] INT_STATIONS = 4'd4;
  localparam logic [CNT_W-1:0] DIV_STATIONS = 4'd4;
  localparam logic [CNT_W-1:0] MUL_STATIONS = 4'd4;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_INT  = 2'd1,
    CLS_DIV  = 2'd2,
    CLS_MUL  = 2'd3
  } cls_e;

  typedef enum logic [2:0] {
    CFG_INT_UNITS = 3'd0,
    CFG_INT_LAT   = 3'd1,
    CFG_DIV_UNITS = 3'd2,
    CFG_DIV_LAT   = 3'd3,
    CFG_MUL_UNITS = 3'd4,
    CFG_MUL_LAT   = 3'd5
  } cfg_idx_e;

  localparam logic [4:0] OP_ADD0 = 5'h00;
  localparam logic [4:0] OP_ADD1 = 5'h01;
  localparam logic [4:0] OP_ADD2 = 5'h02;
  localparam logic [4:0] OP_ADD3 = 5'h03;
  localparam logic [4:0] OP_LI0  = 5'h10;
  localparam logic [4:0] OP_LI1  = 5'h11;
  localparam logic [4:0] OP_LI2  = 5'h12;
  localparam logic [4:0] OP_NOD0 = 5'h0E;
  localparam logic [4:0] OP_NOD1 = 5'h0D;
  localparam logic [4:0] OP_DIV0 = 5'h04;
  localparam logic [4:0] OP_DIV1 = 5'h07;
  localparam logic [4:0] OP_DIV2 = 5'h06;
  localparam logic [4:0] OP_MUL  = 5'h05;

  typedef struct packed {
    cls_e cls;
    logic srcs;
    logic dst;
  } dec_t;

  typedef struct packed {
    logic             wait_i;
    logic             wait_j;
    logic [TAG_W-1:0] tag_i;
    logic [TAG_W-1:0] tag_j;
  } iss_t;

  typedef struct packed {
    logic live;   // valid after retirement
    logic cand;   // read done, sources ready, waiting for a unit
    logic gone;   // retires this cycle
  } cell_stat_t;

  function automatic dec_t decode(input logic [4:0] op);
    dec_t d;
    d = '{cls: CLS_NONE, srcs: 1'b0, dst: 1'b0};
    unique case (op)
      OP_ADD0, OP_ADD1, OP_ADD2, OP_ADD3: d = '{cls: CLS_INT, srcs: 1'b1, dst: 1'b1};
      OP_LI0, OP_LI1, OP_LI2:             d = '{cls: CLS_INT, srcs: 1'b0, dst: 1'b1};
      OP_NOD0, OP_NOD1:                   d = '{cls: CLS_INT, srcs: 1'b0, dst: 1'b0};
      OP_DIV0, OP_DIV1, OP_DIV2:          d = '{cls: CLS_DIV, srcs: 1'b1, dst: 1'b1};
      OP_MUL:                             d = '{cls: CLS_MUL, srcs: 1'b1, dst: 1'b1};
      default:                            d = '{cls: CLS_NONE, srcs: 1'b0, dst: 1'b0};
    endcase
    return d;
  endfunction

endpackage

>>> sv/reservation_station_scheduler.sv
// Tomasulo-style reservation station scheduler. One request models one machine
// cycle: retire, wake/start and issue all complete in that single clock, so a
// request is taken every cycle the result register is free or being drained.
// Each class is a row of station cells; a status table maps each of 8 registers
// to its pending producer. Config writes go straight in.
// Depends on rss_pkg, rss_class.
module reservation_station_scheduler import rss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // instr_valid, instruction[16], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // stalled, issued_class[2], int_done[3],
                                     // div_done[3], mul_done[3], freed_registers[8],
                                     // all_idle, zero pad
);

  logic [3:0] units_q [NCLASS];
  logic [7:0] lat_q   [NCLASS];
  logic [CNT_W-1:0] occ_q [NCLASS], occ_d [NCLASS];
  logic [CNT_W-1:0] busy_q [NCLASS], busy_d [NCLASS];
  logic [TAG_W-1:0] prod_q [REG_COUNT], prod_d [REG_COUNT];
  logic [CNT_W-1:0] cap [NCLASS];
  logic        out_vld_q;
  logic [20:0] out_q, out_d;
  logic        step;

  logic [SLOTS-1:0] gone [NCLASS];
  logic [NCLASS-1:0] found, live, do_issue;
  logic [CNT_W-1:0] starts [NCLASS];
  logic [SLOT_W-1:0] pick [NCLASS];
  logic [RETIRED_W-1:0] retired;
  logic [2:0] done [NCLASS];
  logic [REG_COUNT-1:0] freed;
  logic [TAG_W-1:0] prod_r [REG_COUNT];
  iss_t iss;
  dec_t dec;
  logic [1:0] cidx;
  logic offered, stalled;
  logic [15:0] ins;

  assign cap[0] = INT_STATIONS;
  assign cap[1] = DIV_STATIONS;
  assign cap[2] = MUL_STATIONS;

  assign s_axis_tready = ~out_vld_q | m_axis_tready;
  assign step          = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b0, out_q};

  assign offered = s_axis_tdata[0];
  assign ins     = s_axis_tdata[16:1];
  assign dec     = decode(ins[15:11]);
  assign cidx    = 2'(dec.cls) - 2'd1;

  always_comb begin
    retired = '0;
    for (int c = 0; c < NCLASS; c++) begin
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < SLOTS; i++) begin
        retired[c*SLOTS+i] = gone[c][i];
        n = n + {3'b0, gone[c][i]};
      end
      done[c] = (n > 4'd7) ? 3'd7 : n[2:0];
    end
    // retirement clears mappings that still name a retiring tag
    for (int r = 0; r < REG_COUNT; r++) begin
      freed[r]  = (prod_q[r] != '0) && retired[prod_q[r] - 5'd1];
      prod_r[r] = freed[r] ? '0 : prod_q[r];
    end
  end

  always_comb begin
    logic [TAG_W-1:0] pi, pj;
    pi = prod_r[ins[7:5]];
    pj = prod_r[ins[4:2]];
    iss = '{wait_i: dec.srcs & (pi != '0), wait_j: dec.srcs & (pj != '0),
            tag_i: (dec.srcs && pi != '0) ? pi - 5'd1 : '0,
            tag_j: (dec.srcs && pj != '0) ? pj - 5'd1 : '0};
    stalled  = 1'b0;
    do_issue = '0;
    if (offered && dec.cls != CLS_NONE) begin
      if (occ_q[cidx] >= cap[cidx] || !found[cidx]) stalled = 1'b1;
      else do_issue[cidx] = 1'b1;
    end
  end

  for (genvar g = 0; g < NCLASS; g++) begin : g_row
    rss_class u_row (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (step),
      .cap_i      (cap[g]),
      .units_i    (units_q[g]),
      .lat_i      (lat_q[g]),
      .busy_i     (busy_q[g]),
      .retired_i  (retired),
      .do_issue_i (do_issue[g]),
      .iss_i      (iss),
      .gone_o     (gone[g]),
      .found_o    (found[g]),
      .any_live_o (live[g]),
      .starts_o   (starts[g]),
      .slot_o     (pick[g])
    );
  end

  always_comb begin
    logic [CNT_W-1:0] busy_s;
    busy_s = '0;
    for (int r = 0; r < REG_COUNT; r++) prod_d[r] = prod_r[r];
    for (int c = 0; c < NCLASS; c++) begin
      occ_d[c]  = ((occ_q[c] + {3'b0, do_issue[c]}) >= {1'b0, done[c]}) ?
                  occ_q[c] + {3'b0, do_issue[c]} - {1'b0, done[c]} : '0;
      // a retiring entry holds its unit until the end of the cycle
      busy_s    = busy_q[c] + starts[c];
      busy_d[c] = (busy_s >= {1'b0, done[c]}) ? busy_s - {1'b0, done[c]} : '0;
      if (do_issue[c] && dec.dst)
        prod_d[ins[10:8]] = TAG_W'(c * SLOTS) + {2'b0, pick[c]} + 5'd1;
    end
    out_d = {~|live, freed, done[2], done[1], done[0],
             (do_issue != '0) ? dec.cls : CLS_NONE, stalled};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      units_q[0] <= 4'd1; lat_q[0] <= 8'd1;
      units_q[1] <= 4'd1; lat_q[1] <= 8'd8;
      units_q[2] <= 4'd1; lat_q[2] <= 8'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INT_UNITS: units_q[0] <= cfg_data_i[3:0];
        CFG_INT_LAT:   lat_q[0]   <= cfg_data_i;
        CFG_DIV_UNITS: units_q[1] <= cfg_data_i[3:0];
        CFG_DIV_LAT:   lat_q[1]   <= cfg_data_i;
        CFG_MUL_UNITS: units_q[2] <= cfg_data_i[3:0];
        CFG_MUL_LAT:   lat_q[2]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      for (int c = 0; c < NCLASS; c++) begin
        occ_q[c] <= '0; busy_q[c] <= '0;
      end
      for (int r = 0; r < REG_COUNT; r++) prod_q[r] <= '0;
    end else begin
      if (step) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
      if (step) begin
        for (int c = 0; c < NCLASS; c++) begin
          occ_q[c]  <= occ_d[c];
          busy_q[c] <= busy_d[c];
        end
        for (int r = 0; r < REG_COUNT; r++) prod_q[r] <= prod_d[r];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_q <= out_d;
  end

endmodule

>>> sv/rss_cell.sv
// One reservation station slot: wait flags, read/run state, latency count, age rank.
// Depends on rss_pkg.
module rss_cell import rss_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 en_i,
  input  logic [RETIRED_W-1:0] retired_i,
  input  logic [7:0]           lat_i,
  input  logic                 start_i,
  input  logic [SLOT_W-1:0]    newrank_i,
  input  logic                 do_issue_i,
  input  iss_t                 iss_i,
  input  logic [SLOT_W-1:0]    issue_rank_i,
  input  logic                 free_i,
  input  logic [CNT_W-1:0]     cnt_i,
  output logic                 free_o,
  output logic [CNT_W-1:0]     cnt_o,
  output cell_stat_t           stat_o,
  output logic [SLOT_W-1:0]    rank_o
);

  logic valid_q, valid_d, read_q, read_d, run_q, run_d;
  logic wi_q, wi_d, wj_q, wj_d;
  logic [TAG_W-1:0] ti_q, ti_d, tj_q, tj_d;
  logic [7:0] rem_q, rem_d;
  logic [SLOT_W-1:0] rank_q, rank_d;
  logic gone, live, wi1, wj1, rdy, take;

  always_comb begin
    gone = valid_q & run_q & (rem_q == 8'd0);
    live = valid_q & ~gone;
    wi1  = wi_q & ~retired_i[ti_q];
    wj1  = wj_q & ~retired_i[tj_q];
    rdy  = ~wi1 & ~wj1;
    take = free_i & en_i & ~live;
  end

  assign free_o = free_i & ~take;
  assign cnt_o  = cnt_i + {{(CNT_W-1){1'b0}}, live};
  assign stat_o = '{live: live, cand: live & rdy & ~run_q & read_q, gone: gone};
  assign rank_o = rank_q;

  always_comb begin
    valid_d = valid_q; read_d = read_q; run_d = run_q;
    wi_d = wi_q; wj_d = wj_q; ti_d = ti_q; tj_d = tj_q;
    rem_d = rem_q; rank_d = rank_q;
    if (do_issue_i && take) begin
      valid_d = 1'b1; read_d = 1'b0; run_d = 1'b0;
      wi_d = iss_i.wait_i; wj_d = iss_i.wait_j;
      ti_d = iss_i.tag_i;  tj_d = iss_i.tag_j;
      rem_d = lat_i; rank_d = issue_rank_i;
    end else if (live) begin
      wi_d = wi1; wj_d = wj1; rank_d = newrank_i;
      if (rdy && !run_q) begin
        if (read_q && start_i) begin
          run_d = 1'b1;
          rem_d = rem_q - 8'd1;
        end else if (!read_q) begin
          read_d = 1'b1;
        end
      end else if (run_q) begin
        rem_d = rem_q - 8'd1;
      end
    end else begin
      valid_d = 1'b0; rank_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0; read_q <= 1'b0; run_q <= 1'b0;
      wi_q <= 1'b0; wj_q <= 1'b0; rank_q <= '0;
    end else if (step_i) begin
      valid_q <= valid_d; read_q <= read_d; run_q <= run_d;
      wi_q <= wi_d; wj_q <= wj_d; rank_q <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      ti_q <= ti_d; tj_q <= tj_d; rem_q <= rem_d;
    end
  end

endmodule

>>> sv/rss_class.sv
// Row of station cells for one unit class: age compaction, oldest-first start, slot pick.
// Depends on rss_pkg and rss_cell.
module rss_class import rss_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [CNT_W-1:0]     cap_i,
  input  logic [3:0]           units_i,
  input  logic [7:0]           lat_i,
  input  logic [CNT_W-1:0]     busy_i,
  input  logic [RETIRED_W-1:0] retired_i,
  input  logic                 do_issue_i,
  input  iss_t                 iss_i,
  output logic [SLOTS-1:0]     gone_o,
  output logic                 found_o,
  output logic                 any_live_o,
  output logic [CNT_W-1:0]     starts_o,
  output logic [SLOT_W-1:0]    slot_o
);

  logic [SLOTS:0]            free_c;
  logic [CNT_W-1:0]          cnt_c [SLOTS+1];
  cell_stat_t                stat [SLOTS];
  logic [SLOT_W-1:0]         rank [SLOTS];
  logic [SLOT_W-1:0]         newrank [SLOTS];
  logic [SLOTS-1:0]          start;

  assign free_c[0] = 1'b1;
  assign cnt_c[0]  = '0;

  // a candidate starts if the free units outnumber the older candidates
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      logic [SLOT_W-1:0] nr, oc;
      nr = '0; oc = '0;
      for (int k = 0; k < SLOTS; k++) begin
        if (stat[k].live && rank[k] < rank[i]) nr = nr + 1'b1;
        if (stat[k].cand && rank[k] < rank[i]) oc = oc + 1'b1;
      end
      newrank[i] = nr;
      start[i] = stat[i].cand &&
                 ({1'b0, busy_i} + {2'b0, oc}) < {1'b0, units_i};
      gone_o[i] = stat[i].gone;
    end
  end

  // start count and the cell that takes an issued request
  always_comb begin
    starts_o = '0;
    slot_o   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      starts_o = starts_o + {{(CNT_W-1){1'b0}}, start[i]};
      if (free_c[i] && !free_c[i+1]) slot_o = SLOT_W'(i);
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    rss_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .step_i       (step_i),
      .en_i         (CNT_W'(g) < cap_i),
      .retired_i    (retired_i),
      .lat_i        (lat_i),
      .start_i      (start[g]),
      .newrank_i    (newrank[g]),
      .do_issue_i   (do_issue_i),
      .iss_i        (iss_i),
      .issue_rank_i (cnt_c[SLOTS][SLOT_W-1:0]),
      .free_i       (free_c[g]),
      .cnt_i        (cnt_c[g]),
      .free_o       (free_c[g+1]),
      .cnt_o        (cnt_c[g+1]),
      .stat_o       (stat[g]),
      .rank_o       (rank[g])
    );
  end

  assign found_o    = ~free_c[SLOTS];
  assign any_live_o = (cnt_c[SLOTS] != '0) | do_issue_i;

endmodule

>>> verif/tb_reservation_station_scheduler.sv
// Testbench for reservation_station_scheduler: drives machine-cycle requests,
// predicts each result with a cycle-level scheduler model and compares fields.
// Depends on rss_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module tb_reservation_station_scheduler;
  import rss_pkg::*;

  typedef struct {
    logic       valid, rd, running, wait_i, wait_j, has_dest;
    logic [4:0] tag_i, tag_j;
    logic [7:0] remain;
    logic [2:0] dest;
  } slot_t;

  typedef struct packed {
    logic       idle;
    logic [7:0] freed;
    logic [2:0] mul_done, div_done, int_done;
    logic [1:0] cls;
    logic       stalled;
  } sched_out_t;

  logic        clk_i = 1'b0, rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0, s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid, m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  reservation_station_scheduler DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // scheduler model state
  slot_t      slots [3][SLOTS];
  logic [2:0] rank [3][SLOTS];
  logic [4:0] producer [REG_COUNT];
  logic [3:0] busy [3];
  logic [3:0] occ [3];
  logic [3:0] units [3];
  logic [7:0] lat [3];
  int         cap [3];

  sched_out_t expected_q [$];
  int         errors = 0;
  bit         noise_idle = 1'b1;
  bit         hold_long = 1'b0;
  int         in_gap_max = 15, out_gap_max = 15;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic sched_out_t predict_cycle(input logic offered, input logic [15:0] ins);
    sched_out_t o;
    logic [31:0] retired;
    logic [2:0] done [3];
    logic gone;
    logic [2:0] nr [SLOTS];
    logic [4:0] op;
    int cls, free_slot, cnt;
    logic srcs, dst;
    logic [4:0] p;
    o = '0;
    retired = '0;
    for (int c = 0; c < 3; c++) done[c] = '0;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < cap[c]; i++) begin
        gone = slots[c][i].valid && slots[c][i].running && slots[c][i].remain == 0;
        if (gone) begin
          retired[c*SLOTS+i] = 1'b1;
          if (done[c] < 7) done[c]++;
          for (int r = 0; r < REG_COUNT; r++)
            if (producer[r] == c*SLOTS+i+1) begin
              producer[r] = '0;
              o.freed[r] = 1'b1;
            end
          slots[c][i].valid = 1'b0;
        end
      end
      for (int i = 0; i < cap[c]; i++) begin
        nr[i] = '0;
        if (slots[c][i].valid)
          for (int k = 0; k < cap[c]; k++)
            if (slots[c][k].valid && rank[c][k] < rank[c][i]) nr[i]++;
      end
      for (int i = 0; i < cap[c]; i++) rank[c][i] = slots[c][i].valid ? nr[i] : '0;
    end
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < SLOTS; r++)
        for (int i = 0; i < cap[c]; i++) begin
          if (!slots[c][i].valid || rank[c][i] != r) continue;
          if (slots[c][i].wait_i && retired[slots[c][i].tag_i]) slots[c][i].wait_i = 1'b0;
          if (slots[c][i].wait_j && retired[slots[c][i].tag_j]) slots[c][i].wait_j = 1'b0;
          if (!slots[c][i].wait_i && !slots[c][i].wait_j && !slots[c][i].running) begin
            if (slots[c][i].rd && busy[c] < units[c]) begin
              slots[c][i].running = 1'b1;
              slots[c][i].remain--;
              busy[c]++;
            end else if (!slots[c][i].rd) slots[c][i].rd = 1'b1;
          end else if (slots[c][i].running) slots[c][i].remain--;
        end
    op = ins[15:11];
    cls = -1; srcs = 1'b0; dst = 1'b0;
    case (op)
      OP_ADD0, OP_ADD1, OP_ADD2, OP_ADD3: begin cls = 0; srcs = 1; dst = 1; end
      OP_LI0, OP_LI1, OP_LI2: begin cls = 0; dst = 1; end
      OP_NOD0, OP_NOD1: cls = 0;
      OP_DIV0, OP_DIV1, OP_DIV2: begin cls = 1; srcs = 1; dst = 1; end
      OP_MUL: begin cls = 2; srcs = 1; dst = 1; end
      default: cls = -1;
    endcase
    if (offered && cls >= 0) begin
      free_slot = -1; cnt = 0;
      for (int i = 0; i < cap[cls]; i++)
        if (slots[cls][i].valid) cnt++;
        else if (free_slot < 0) free_slot = i;
      if (occ[cls] >= cap[cls] || free_slot < 0) o.stalled = 1'b1;
      else begin
        slots[cls][free_slot] = '{default: '0};
        slots[cls][free_slot].valid = 1'b1;
        if (srcs) begin
          p = producer[ins[7:5]];
          slots[cls][free_slot].wait_i = p != 0;
          slots[cls][free_slot].tag_i = p != 0 ? p - 5'd1 : '0;
          p = producer[ins[4:2]];
          slots[cls][free_slot].wait_j = p != 0;
          slots[cls][free_slot].tag_j = p != 0 ? p - 5'd1 : '0;
        end
        slots[cls][free_slot].has_dest = dst;
        slots[cls][free_slot].dest = ins[10:8];
        if (dst) producer[ins[10:8]] = 5'(cls*SLOTS + free_slot + 1);
        slots[cls][free_slot].remain = lat[cls];
        rank[cls][free_slot] = 3'(cnt);
        occ[cls]++;
        o.cls = 2'(cls + 1);
      end
    end
    for (int c = 0; c < 3; c++) begin
      occ[c] = occ[c] >= done[c] ? occ[c] - done[c] : '0;
      busy[c] = busy[c] >= done[c] ? busy[c] - done[c] : '0;
    end
    o.int_done = done[0]; o.div_done = done[1]; o.mul_done = done[2];
    o.idle = 1'b1;
    for (int c = 0; c < 3; c++)
      for (int i = 0; i < cap[c]; i++) if (slots[c][i].valid) o.idle = 1'b0;
    return o;
  endfunction

  // ready is stable through the low phase, so it is sampled just after the falling edge
  task automatic send_cycle(input logic offered, input logic [15:0] ins);
    if (noise_idle && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, in_gap_max)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, ins, offered};
    #1;
    while (!s_axis_tready) begin
      @(negedge clk_i);
      #1;
    end
    @(posedge clk_i);
    expected_q.push_back(predict_cycle(offered, ins));
    @(negedge clk_i);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0 && guard < 200000) begin @(negedge clk_i); guard++; end
    repeat (300) @(negedge clk_i);  // long latencies may keep entries live
  endtask

  // waits until every station is empty so config changes land while idle
  task automatic run_to_idle;
    int guard;
    guard = 0;
    drain();
    while (guard < 20000) begin
      bit live;
      live = 0;
      for (int c = 0; c < 3; c++)
        for (int i = 0; i < cap[c]; i++) if (slots[c][i].valid) live = 1;
      if (!live) break;
      send_cycle(1'b0, 16'h0);
      guard++;
    end
    drain();
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [7:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_INT_UNITS: units[0] = val[3:0];
      CFG_INT_LAT:   lat[0] = val;
      CFG_DIV_UNITS: units[1] = val[3:0];
      CFG_DIV_LAT:   lat[1] = val;
      CFG_MUL_UNITS: units[2] = val[3:0];
      default:       lat[2] = val;
    endcase
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_instr(input bit legal);
    logic [4:0] ops [13];
    ops = '{OP_ADD0, OP_ADD1, OP_ADD2, OP_ADD3, OP_LI0, OP_LI1, OP_LI2,
            OP_NOD0, OP_NOD1, OP_DIV0, OP_DIV1, OP_DIV2, OP_MUL};
    if (legal) return {ops[$urandom_range(0, 12)], 11'($urandom)};
    return 16'($urandom);
  endfunction

  // checker
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sched_out_t got, want;
      got = m_axis_tdata[20:0];
      if (expected_q.size() == 0) report_mismatch("unexpected result", got, 0);
      else begin
        want = expected_q.pop_front();
        if (got.stalled !== want.stalled) report_mismatch("stalled", got.stalled, want.stalled);
        if (got.cls !== want.cls) report_mismatch("issued_class", got.cls, want.cls);
        if (got.int_done !== want.int_done) report_mismatch("int_done", got.int_done, want.int_done);
        if (got.div_done !== want.div_done) report_mismatch("div_done", got.div_done, want.div_done);
        if (got.mul_done !== want.mul_done) report_mismatch("mul_done", got.mul_done, want.mul_done);
        if (got.freed !== want.freed) report_mismatch("freed_registers", got.freed, want.freed);
        if (got.idle !== want.idle) report_mismatch("all_idle", got.idle, want.idle);
      end
    end
  end

  // receiver backpressure
  always @(negedge clk_i) begin
    if (hold_long) m_axis_tready <= 1'b0;
    else if (noise_idle && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, out_gap_max)) @(negedge clk_i);
      m_axis_tready <= 1'b1;
    end else m_axis_tready <= 1'b1;
  end

  task automatic test_directed;
    send_cycle(1'b1, {OP_LI0, 3'd1, 8'h00});
    send_cycle(1'b1, {OP_ADD0, 3'd2, 3'd1, 3'd1, 2'b11});
    send_cycle(1'b1, {OP_ADD3, 3'd7, 3'd0, 3'd2, 2'b00}); // second source waits alone
    send_cycle(1'b1, {OP_LI1, 3'd0, 8'hFF});
    send_cycle(1'b1, {OP_LI2, 3'd3, 8'h00});
    send_cycle(1'b1, {OP_NOD0, 11'h7FF});
    send_cycle(1'b1, {OP_NOD1, 11'h000});
    send_cycle(1'b1, {OP_DIV0, 3'd4, 3'd2, 3'd7, 2'b00});
    send_cycle(1'b1, {OP_DIV1, 3'd5, 3'd4, 3'd4, 2'b00});
    send_cycle(1'b1, {OP_DIV2, 3'd6, 3'd5, 3'd1, 2'b00});
    send_cycle(1'b1, {OP_MUL, 3'd1, 3'd6, 3'd5, 2'b00});
    send_cycle(1'b1, 16'hFFFF);                 // other opcode
    send_cycle(1'b0, {OP_ADD1, 11'h555});        // not offered
    repeat (6) send_cycle(1'b1, {OP_ADD2, 3'd3, 3'd3, 3'd3, 2'b00}); // fill int row
    repeat (5) send_cycle(1'b1, {OP_MUL, 3'd2, 3'd2, 3'd2, 2'b00});
    run_to_idle();
  endtask

  task automatic test_config_sweep;
    logic [7:0] l;
    for (int k = 0; k < 5; k++) begin
      for (int c = 0; c < 3; c++) begin
        l = (k == 0) ? 8'd1 : (k == 1) ? 8'd255 : (k == 2) ? 8'd0 : 8'($urandom_range(1, 12));
        write_cfg(cfg_idx_e'(2*c), (k == 1) ? 8'd8 : (k == 2) ? 8'd1 : 8'($urandom_range(1, 8)));
        write_cfg(cfg_idx_e'(2*c+1), l);
      end
      repeat ((k == 1 || k == 2) ? 20 : 120) send_cycle($urandom_range(0, 9) != 0,
                                                   rand_instr($urandom_range(0, 9) != 0));
      run_to_idle();
    end
  endtask

  task automatic test_backpressure;
    hold_long = 1'b1;
    fork
      begin repeat (60) @(negedge clk_i); hold_long = 1'b0; end
      repeat (30) send_cycle(1'b1, rand_instr(1));
    join
    run_to_idle();
  endtask

  task automatic test_random_tail;
    write_cfg(CFG_INT_UNITS, 8'd2); write_cfg(CFG_INT_LAT, 8'd3);
    write_cfg(CFG_DIV_UNITS, 8'd1); write_cfg(CFG_DIV_LAT, 8'd6);
    write_cfg(CFG_MUL_UNITS, 8'd3); write_cfg(CFG_MUL_LAT, 8'd2);
    repeat (120) send_cycle(1'b1, rand_instr($urandom_range(0, 4) != 0));
    noise_idle = 1'b0;
    repeat (80) send_cycle($urandom_range(0, 5) != 0, rand_instr(1));
    run_to_idle();
  endtask

  initial begin
    units = '{4'd1, 4'd1, 4'd1};
    lat = '{8'd1, 8'd8, 8'd4};
    cap = '{int'(INT_STATIONS), int'(DIV_STATIONS), int'(MUL_STATIONS)};
    foreach (slots[c, i]) begin slots[c][i] = '{default: '0}; rank[c][i] = '0; end
    foreach (producer[r]) producer[r] = '0;
    busy = '{default: '0}; occ = '{default: '0};
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random_tail();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("reservation_station_scheduler verification clean");
    end else begin
      $display("reservation_station_scheduler verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("reservation_station_scheduler verification failed");
    $finish;
  end
endmodule
